[rtl/core/kmp_pkg.sv]
// Shared types and constants for the streaming KMP matcher.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package kmp_pkg;

    // Fixed field and register widths.
    localparam int TEXT_W    = 8;
    localparam int START_W   = 32;
    localparam int REG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int PLEN_W    = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

    // Which address drives the single failure-table read port.
    typedef enum logic [1:0] {
        RD_RUN,
        RD_MATCH,
        RD_LAST
    } rd_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    build_init;
        logic    build_step;
        logic    accept;
        logic    fallback;
        logic    advance;
        logic    wrap_commit;
        rd_sel_t rd_sel;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cfg_hit;
        logic build_done;
        logic fallback;
        logic scan_end;
        logic out_free;
    } sts_t;

endpackage

[rtl/core/kmp_ctrl.sv]
// Controller state machine for the KMP matcher: table build and byte scan sequencing.
// Depends on kmp_pkg for the command and status structs.
`timescale 1ns / 1ps

module kmp_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  kmp_pkg::sts_t sts,
    output kmp_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_START,
        ST_BUILD,
        ST_IDLE,
        ST_SCAN,
        ST_WRAP
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Input beats are taken only between items, once the table is built.
    assign s_ready = (state_reg == ST_IDLE);

    // Command decode.
    always_comb begin
        cmd             = '0;
        cmd.rd_sel      = kmp_pkg::RD_RUN;
        cmd.build_init  = sts.cfg_hit || (state_reg == ST_START);
        cmd.build_step  = (state_reg == ST_BUILD) && !sts.build_done && !sts.cfg_hit;
        cmd.accept      = (state_reg == ST_IDLE) && s_valid && !sts.cfg_hit;
        cmd.fallback    = (state_reg == ST_SCAN) && sts.fallback;
        cmd.advance     = (state_reg == ST_SCAN) && !sts.fallback && !sts.scan_end
                          && sts.out_free;
        cmd.wrap_commit = (state_reg == ST_WRAP) && sts.out_free;
        case (state_reg)
            ST_SCAN: begin
                cmd.rd_sel = kmp_pkg::RD_MATCH;
            end
            ST_WRAP: begin
                cmd.rd_sel = kmp_pkg::RD_LAST;
            end
            default: begin
                cmd.rd_sel = kmp_pkg::RD_RUN;
            end
        endcase
    end

    // Next-state logic; a write to a pattern register always restarts the table build.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_START: begin
                state_next = ST_BUILD;
            end
            ST_BUILD: begin
                if (sts.build_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (sts.fallback) begin
                    state_next = ST_SCAN;
                end else if (sts.scan_end) begin
                    state_next = ST_WRAP;
                end else if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_WRAP: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_START;
            end
        endcase
        if (sts.cfg_hit) begin
            state_next = ST_BUILD;
        end
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_START;
        end else begin
            state_reg <= state_next;
        end
    end

    // A valid register write always sends the controller back to building the table.
    a_cfg_rebuilds : assert property (@(posedge aclk) disable iff (!aresetn)
        sts.cfg_hit |=> (state_reg == ST_BUILD))
        else $error("register write did not restart the table build");

endmodule

[rtl/core/kmp_datapath.sv]
// Datapath for the KMP matcher: configuration registers, failure table, match state,
// text offset and the output register. Depends on kmp_pkg.
`timescale 1ns / 1ps

module kmp_datapath #(
    parameter int PATTERN_MAX = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [kmp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kmp_pkg::REG_W-1:0]       cfg_wdata,
    input  logic [kmp_pkg::TEXT_W-1:0]      s_text_byte,
    input  logic                            s_restart,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_match_found,
    output logic [kmp_pkg::START_W-1:0]     m_match_start,
    input  kmp_pkg::cmd_t                   cmd,
    output kmp_pkg::sts_t                   sts
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int SUM_W = (OFFSET_BITS + 1 > kmp_pkg::START_W) ? OFFSET_BITS + 1
                                                                 : kmp_pkg::START_W;

    // Configuration registers.
    logic [kmp_pkg::REG_W-1:0]    pattern_low_reg;
    logic [kmp_pkg::REG_W-1:0]    pattern_high_reg;
    logic [kmp_pkg::PLEN_W-1:0]   pattern_length_reg;
    logic [2*kmp_pkg::REG_W-1:0]  pat_vec;

    // Failure table and build pointers.
    logic [IDX_W-1:0]             ft_reg [PATTERN_MAX];
    logic [LEN_W-1:0]             pos_reg;
    logic [LEN_W-1:0]             run_reg;

    // Match state and offsets.
    logic [LEN_W-1:0]             j_reg;
    logic [OFFSET_BITS-1:0]       offset_reg;
    logic [OFFSET_BITS-1:0]       here_reg;
    logic [kmp_pkg::TEXT_W-1:0]   byte_reg;

    // Output register.
    logic                         m_valid_reg;
    logic                         m_match_found_reg;
    logic [kmp_pkg::START_W-1:0]  m_match_start_reg;

    logic [LEN_W-1:0]             m_eff;
    logic [LEN_W-1:0]             rd_base;
    logic [LEN_W-1:0]             rd_dec;
    logic [IDX_W-1:0]             rd_idx;
    logic [IDX_W-1:0]             ft_rd;
    logic [kmp_pkg::TEXT_W-1:0]   pb_pos;
    logic [kmp_pkg::TEXT_W-1:0]   pb_run;
    logic [kmp_pkg::TEXT_W-1:0]   pb_j;
    logic                         build_eq;
    logic                         scan_eq;
    logic [LEN_W-1:0]             run_inc;
    logic [OFFSET_BITS-1:0]       base_offset;
    logic [SUM_W-1:0]             start_sum;
    logic [SUM_W-1:0]             start_len;
    logic [SUM_W-1:0]             start_wide;
    logic                         out_free;

    // Picks pattern byte k out of the concatenated pattern registers.
    function automatic logic [kmp_pkg::TEXT_W-1:0] pat_byte(
        input logic [2*kmp_pkg::REG_W-1:0] v,
        input logic [3:0]                  k
    );
        logic [6:0] bit_pos;
        bit_pos  = {k, 3'b000};
        pat_byte = v[bit_pos +: kmp_pkg::TEXT_W];
    endfunction

    assign pat_vec = {pattern_high_reg, pattern_low_reg};

    // Effective pattern length: zero acts as one, large values clamp to the maximum.
    always_comb begin
        if (pattern_length_reg == '0) begin
            m_eff = LEN_W'(1);
        end else if (pattern_length_reg > kmp_pkg::PLEN_W'(PATTERN_MAX)) begin
            m_eff = LEN_W'(PATTERN_MAX);
        end else begin
            m_eff = LEN_W'(pattern_length_reg);
        end
    end

    // Single failure-table read port, address chosen by the controller.
    always_comb begin
        case (cmd.rd_sel)
            kmp_pkg::RD_RUN: begin
                rd_base = run_reg;
            end
            kmp_pkg::RD_MATCH: begin
                rd_base = j_reg;
            end
            default: begin
                rd_base = m_eff;
            end
        endcase
    end

    assign rd_dec = rd_base - LEN_W'(1);
    assign rd_idx = rd_dec[IDX_W-1:0];
    assign ft_rd  = ft_reg[rd_idx];

    // Byte compares for the table build and for the text scan.
    assign pb_pos   = pat_byte(pat_vec, 4'(pos_reg[IDX_W-1:0]));
    assign pb_run   = pat_byte(pat_vec, 4'(run_reg[IDX_W-1:0]));
    assign pb_j     = pat_byte(pat_vec, 4'(j_reg[IDX_W-1:0]));
    assign build_eq = (pb_pos == pb_run);
    assign scan_eq  = (pb_j == byte_reg);
    assign run_inc  = run_reg + LEN_W'(1);

    // Offset of the incoming byte, cleared by restart.
    assign base_offset = s_restart ? '0 : offset_reg;

    // Match start: offset + 1 - length, guarded against going below zero.
    assign start_sum  = SUM_W'(here_reg) + SUM_W'(1);
    assign start_len  = SUM_W'(m_eff);
    assign start_wide = (start_sum >= start_len) ? (start_sum - start_len) : '0;

    assign out_free = !m_valid_reg || m_ready;

    // Status back to the controller.
    always_comb begin
        sts.cfg_hit    = cfg_wr_en && ((cfg_index == kmp_pkg::REG_PATTERN_LOW)
                         || (cfg_index == kmp_pkg::REG_PATTERN_HIGH)
                         || (cfg_index == kmp_pkg::REG_PATTERN_LENGTH));
        sts.build_done = (pos_reg >= m_eff);
        sts.fallback   = (j_reg != '0) && !scan_eq;
        sts.scan_end   = scan_eq && ((j_reg + LEN_W'(1)) == m_eff);
        sts.out_free   = out_free;
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= kmp_pkg::PLEN_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                kmp_pkg::REG_PATTERN_LOW: begin
                    pattern_low_reg <= cfg_wdata;
                end
                kmp_pkg::REG_PATTERN_HIGH: begin
                    pattern_high_reg <= cfg_wdata;
                end
                kmp_pkg::REG_PATTERN_LENGTH: begin
                    pattern_length_reg <= cfg_wdata[kmp_pkg::PLEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Build pointers and matched length.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= LEN_W'(1);
            run_reg <= '0;
            j_reg   <= '0;
        end else if (cmd.build_init) begin
            pos_reg <= LEN_W'(1);
            run_reg <= '0;
            j_reg   <= '0;
        end else begin
            if (cmd.build_step) begin
                if (build_eq) begin
                    run_reg <= run_inc;
                    pos_reg <= pos_reg + LEN_W'(1);
                end else if (run_reg == '0) begin
                    pos_reg <= pos_reg + LEN_W'(1);
                end else begin
                    run_reg <= LEN_W'(ft_rd);
                end
            end
            if (cmd.accept) begin
                if (s_restart || (j_reg >= m_eff)) begin
                    j_reg <= '0;
                end
            end else if (cmd.fallback) begin
                j_reg <= LEN_W'(ft_rd);
            end else if (cmd.advance) begin
                j_reg <= j_reg + LEN_W'(scan_eq);
            end else if (cmd.wrap_commit) begin
                j_reg <= LEN_W'(ft_rd);
            end
        end
    end

    // Failure table writes; entry zero is always zero.
    always_ff @(posedge aclk) begin
        if (cmd.build_init) begin
            ft_reg[0] <= '0;
        end else if (cmd.build_step) begin
            if (build_eq) begin
                ft_reg[pos_reg[IDX_W-1:0]] <= run_inc[IDX_W-1:0];
            end else if (run_reg == '0) begin
                ft_reg[pos_reg[IDX_W-1:0]] <= '0;
            end
        end
    end

    // Text offset, saturating at its all-ones value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
        end else if (cmd.accept) begin
            if (&base_offset) begin
                offset_reg <= base_offset;
            end else begin
                offset_reg <= base_offset + OFFSET_BITS'(1);
            end
        end
    end

    // Captured input beat.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            here_reg <= base_offset;
            byte_reg <= s_text_byte;
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.advance || cmd.wrap_commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (cmd.advance) begin
            m_match_found_reg <= 1'b0;
            m_match_start_reg <= '0;
        end else if (cmd.wrap_commit) begin
            m_match_found_reg <= 1'b1;
            m_match_start_reg <= start_wide[kmp_pkg::START_W-1:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_match_found = m_match_found_reg;
    assign m_match_start = m_match_start_reg;

    // A result is only loaded when the output register can take it.
    a_no_overwrite : assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.advance || cmd.wrap_commit) |-> out_free)
        else $error("result loaded over a pending output beat");

    // The matched length stays below the effective pattern length.
    a_len_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (j_reg < m_eff))
        else $error("matched length reached the pattern length");

    // The build pointer never runs past the pattern length.
    a_pos_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (pos_reg <= m_eff))
        else $error("build pointer ran past the pattern length");

endmodule

[rtl/core/kmp_stream_matcher.sv]
// Top level of the streaming KMP matcher: joins the controller and the datapath.
// Depends on kmp_pkg, kmp_ctrl and kmp_datapath.
`timescale 1ns / 1ps

// Searches a byte stream for a pattern of up to PATTERN_MAX bytes and returns one
// result beat per text byte: a match flag and, on a match, the zero-based offset where
// the match begins (overlapping matches are reported). Each text byte is accepted, then
// scanned, with a failure-table fallback step each time it mismatches a partial match
// and a wrap step when the pattern completes; its result beat is presented as soon as
// the scan ends, and a result still waiting in the output register holds the scan.
// Fallback steps run one after another, as the failure table has a single read port.
// Any write to a pattern register clears the matched length and rebuilds the failure
// table, which also runs once after reset; no text beats are accepted meanwhile. Set
// restart on the first byte of a new text to clear the match state and the offset;
// the offset saturates at its maximum.
module kmp_stream_matcher #(
    parameter int PATTERN_MAX = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [kmp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kmp_pkg::REG_W-1:0]       cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [kmp_pkg::TEXT_W-1:0]      s_text_byte,
    input  logic                            s_restart,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_match_found,
    output logic [kmp_pkg::START_W-1:0]     m_match_start
);

    kmp_pkg::cmd_t cmd;
    kmp_pkg::sts_t sts;

    // Sequencing of the table build and the per-byte scan.
    kmp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Storage, compares and the output register.
    kmp_datapath #(
        .PATTERN_MAX (PATTERN_MAX),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_text_byte   (s_text_byte),
        .s_restart     (s_restart),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_match_found (m_match_found),
        .m_match_start (m_match_start),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule
